/* src/tce_pkg.sv */
package tce_pkg;

  localparam int PF_W    = 31;
  localparam int VOL_W   = 28;
  localparam int FA_W    = 25;
  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 3;
  localparam int EXP_BITS  = 29;
  localparam int EXP_IDX_W = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLASMA_FLOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERM_SURFACE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_VOLUME  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLASMA_VOLUME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ART_FRACTION  = 3'd4;

  localparam logic [63:0] RATE_MAX = 64'h0000_00FF_FFFF_FFFF;
  localparam logic [63:0] ONE_Q24  = 64'd16777216;
  localparam logic [63:0] EXP_ONE  = 64'h4000_0000_0000_0000;
  localparam logic [63:0] EXP_SEED = 64'h3FFF_FFC0_0000_2000;
  localparam logic [63:0] CONV_LIM = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] BIG_LIM  = 64'h3FFF_FFFF_FFFF_FFFF;

  // divide / square-root unit operations
  localparam logic DS_DIV  = 1'b0;
  localparam logic DS_SQRT = 1'b1;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic         start;
    logic         op;
    logic [127:0] num;
    logic [63:0]  den;
    logic [63:0]  cap;
  } ds_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } ds_rsp_t;

endpackage

/* src/tce_if.sv */
interface tce_in_if;
  logic               valid;
  logic               ready;
  logic               series_start;
  logic [31:0]        sample_time;
  logic signed [31:0] arterial_conc;
  logic signed [31:0] venous_conc;

  modport source (output valid, series_start, sample_time, arterial_conc, venous_conc,
                  input ready);
  modport sink (input valid, series_start, sample_time, arterial_conc, venous_conc,
                output ready);
endinterface

interface tce_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] tissue_conc;
  logic               model_error;

  modport source (output valid, tissue_conc, model_error, input ready);
  modport sink (input valid, tissue_conc, model_error, output ready);
endinterface

/* src/tce_mul.sv */
module tce_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  tce_pkg::mul_req_t req,
  output tce_pkg::mul_rsp_t rsp
);

  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r;
  logic [1:0]   cnt_r;
  logic         busy_r, done_r;
  logic [31:0]  ha, hb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  // one 32x32 partial product per cycle
  always_comb begin
    ha = cnt_r[1] ? a_r[63:32] : a_r[31:0];
    hb = cnt_r[0] ? b_r[63:32] : b_r[31:0];
    pp = ha * hb;
    pp_sh = {64'd0, pp};
    if (cnt_r == 2'd3) begin
      pp_sh = {pp, 64'd0};
    end else if (cnt_r != 2'd0) begin
      pp_sh = {32'd0, pp, 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == 2'd3);
      if (req.start) begin
        a_r    <= req.a;
        b_r    <= req.b;
        acc_r  <= 128'd0;
        cnt_r  <= 2'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_r + pp_sh;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

/* src/tce_divsqrt.sv */
module tce_divsqrt (
  input  logic             clk,
  input  logic             rst_n,
  input  tce_pkg::ds_req_t req,
  output tce_pkg::ds_rsp_t rsp
);

  logic         busy_r, done_r, op_r, ovf_r;
  logic [6:0]   cnt_r;
  logic [127:0] num_r;
  logic [63:0]  den_r, cap_r, ql_r, res_r, root_r;
  logic [64:0]  rem_r;

  logic [63:0]  rsh, drem, dql;
  logic         dsub, dovf, sge, last;
  logic [66:0]  remx, trial, srem;
  logic [63:0]  sroot;

  always_comb begin
    // restoring division, one quotient bit a cycle
    rsh  = {rem_r[62:0], num_r[127]};
    dsub = rem_r[63] || (rsh >= den_r);
    drem = dsub ? rsh - den_r : rsh;
    dql  = {ql_r[62:0], dsub};
    dovf = ovf_r | ql_r[63];
    // digit-by-digit square root, one root bit a cycle
    remx  = {rem_r, num_r[127:126]};
    trial = {1'b0, root_r, 2'b01};
    sge   = remx >= trial;
    srem  = sge ? remx - trial : remx;
    sroot = {root_r[62:0], sge};
    last  = (op_r == tce_pkg::DS_SQRT) ? (cnt_r == 7'd63) : (cnt_r == 7'd127);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= req.start ? (req.op == tce_pkg::DS_DIV && req.den == 64'd0)
                          : (busy_r && last);
      if (req.start) begin
        op_r   <= req.op;
        num_r  <= req.num;
        den_r  <= req.den;
        cap_r  <= req.cap;
        rem_r  <= 65'd0;
        ql_r   <= 64'd0;
        root_r <= 64'd0;
        ovf_r  <= 1'b0;
        cnt_r  <= 7'd0;
        if (req.op == tce_pkg::DS_DIV && req.den == 64'd0) begin
          res_r  <= req.cap;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (op_r == tce_pkg::DS_SQRT) begin
          rem_r  <= srem[64:0];
          root_r <= sroot;
          num_r  <= {num_r[125:0], 2'b00};
          if (last) begin
            res_r  <= sroot;
            busy_r <= 1'b0;
          end
        end else begin
          rem_r <= {1'b0, drem};
          ql_r  <= dql;
          ovf_r <= dovf;
          num_r <= {num_r[126:0], 1'b0};
          if (last) begin
            res_r  <= (dovf || dql > cap_r) ? cap_r : dql;
            busy_r <= 1'b0;
          end
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

/* src/two_compartment_exchange_conc.sv */
// Dual-input two-compartment exchange tissue model for one voxel, streamed.
// in_chan carries one time sample per transaction: series start flag, time
// (Q16.16) and arterial / portal-venous concentration (Q12.20). out_chan
// returns one transaction per sample: tissue concentration and an error flag.
// cfg_we / cfg_index / cfg_wdata write the five model registers; write them
// only while the block is idle. The arterial fraction is used on every
// sample, the rest is taken up at the next series start.
// All multiplies run on one shared 64x64 multiplier (one 32x32 partial
// product a cycle), and divides and square roots on one bit-serial divide /
// square root unit. For each of the two exponent arguments, an ordinary
// sample takes a table multiply per set bit and a shift step per clear bit
// below its top set bit. A two-compartment series start runs a 64-step
// square root and up to three 128-step divisions. in_chan.ready is high
// only while the sequencer is idle.
// After reset the exponential table is built by repeated squaring, with
// in_chan.ready low. The result sits in an output register, so a stalled
// receiver does not hold up the next sample; a second result waits in the
// sequencer until the register drains.
module two_compartment_exchange_conc (
  input  logic                               clk,
  input  logic                               rst_n,
  tce_in_if.sink                             in_chan,
  tce_out_if.source                          out_chan,
  input  logic                               cfg_we,
  input  logic [tce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tce_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam logic [4:0] S_TAB  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_CPA  = 5'd2;
  localparam logic [4:0] S_CPV  = 5'd3;
  localparam logic [4:0] S_ADV  = 5'd4;
  localparam logic [4:0] S_X    = 5'd5;
  localparam logic [4:0] S_EXP  = 5'd6;
  localparam logic [4:0] S_S    = 5'd7;
  localparam logic [4:0] S_ADD  = 5'd8;
  localparam logic [4:0] S_DEC  = 5'd9;
  localparam logic [4:0] S_OF   = 5'd10;
  localparam logic [4:0] S_OS   = 5'd11;
  localparam logic [4:0] S_OUT  = 5'd12;
  localparam logic [4:0] S_D0   = 5'd13;
  localparam logic [4:0] S_AVT  = 5'd14;
  localparam logic [4:0] S_FEV  = 5'd15;
  localparam logic [4:0] S_N2   = 5'd16;
  localparam logic [4:0] S_AF   = 5'd17;
  localparam logic [4:0] S_EP   = 5'd18;
  localparam logic [4:0] S_M    = 5'd19;
  localparam logic [4:0] S_SQ   = 5'd20;
  localparam logic [4:0] S_RF   = 5'd21;
  localparam logic [4:0] S_RS   = 5'd22;
  localparam logic [4:0] S_NE   = 5'd23;
  localparam logic [4:0] S_FF   = 5'd24;
  localparam logic [4:0] S_K    = 5'd25;

  // model registers
  logic [30:0] pf_r;
  logic [27:0] ps_r, ev_r, pv_r;
  logic [24:0] fa_r;

  // sample being worked on
  logic               st_r;
  logic [31:0]        t_r;
  logic signed [31:0] ca_r, cv_r;

  // model state
  logic [31:0]        prev_time_r;
  logic signed [31:0] prev_cp_r;
  logic signed [47:0] conv_fast_r, conv_slow_r;
  logic [39:0]        rate_fast_r, rate_slow_r;
  logic [30:0]        flow_fast_r, flow_slow_r;
  logic               invalid_r;

  // sequencer and working registers
  logic [4:0]         state_r;
  logic               issued_r;
  logic               term_r;
  logic signed [32:0] pa_r;
  logic signed [31:0] cp_r;
  logic [28:0]        xb_r;
  logic [tce_pkg::EXP_IDX_W-1:0] bidx_r, tidx_r;
  logic [63:0]        eacc_r;
  logic [30:0]        e_r;
  logic signed [33:0] s_r;
  logic signed [47:0] add_r;
  logic signed [50:0] o1_r;
  logic signed [31:0] c_r;
  logic [63:0]        tab_r [tce_pkg::EXP_BITS];

  // series start derivation
  logic [56:0]  avt_r;
  logic [59:0]  n_r, r_r;
  logic [119:0] n2_r;
  logic [58:0]  af_r;
  logic [55:0]  ep_r;

  // output register
  logic               out_valid_r;
  logic signed [31:0] out_conc_r;
  logic               out_err_r;

  tce_pkg::mul_req_t mul_req;
  tce_pkg::mul_rsp_t mul_rsp;
  tce_pkg::ds_req_t  ds_req;
  tce_pkg::ds_rsp_t  ds_rsp;

  logic         mul_go, ds_go, fire, out_load;
  logic [127:0] p;
  logic [31:0]  dt;
  logic [24:0]  fa_c;
  logic [28:0]  vt;
  logic [39:0]  cur_rate;
  logic signed [47:0] cur_conv;
  logic [60:0]  npr;
  logic [57:0]  twoav;
  logic [60:0]  ne;
  logic [127:0] m_full;
  logic [127:0] rate_num;
  logic signed [63:0] sc24a, sc24v, sc30s, sc13, sc30d, sc28f, sc28s;
  logic signed [63:0] cp_sum, dec_sum, out_sum;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'd0 - v : v;
  endfunction

  // scale a magnitude product, saturate, restore the sign (truncates to zero)
  function automatic logic signed [63:0] scale(input logic [127:0] prod, input int sh,
                                               input logic [63:0] lim, input logic neg);
    logic [127:0] q;
    logic [63:0]  mg;
    q  = prod >> sh;
    mg = (|q[127:64] || q[63:0] > lim) ? lim : q[63:0];
    scale = neg ? 64'd0 - mg : mg;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      clamp32 = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      clamp32 = 32'h8000_0000;
    end else begin
      clamp32 = v[31:0];
    end
  endfunction

  function automatic logic signed [47:0] clamp_conv(input logic signed [63:0] v);
    if (v > $signed(tce_pkg::CONV_LIM)) begin
      clamp_conv = tce_pkg::CONV_LIM[47:0];
    end else if (v < -$signed(tce_pkg::CONV_LIM)) begin
      clamp_conv = 48'd0 - tce_pkg::CONV_LIM[47:0];
    end else begin
      clamp_conv = v[47:0];
    end
  endfunction

  tce_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  tce_divsqrt u_divsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ds_req),
    .rsp   (ds_rsp)
  );

  always_comb begin
    p        = mul_rsp.prod;
    dt       = (t_r >= prev_time_r) ? t_r - prev_time_r : 32'd0;
    fa_c     = (fa_r > tce_pkg::ONE_Q24[24:0]) ? tce_pkg::ONE_Q24[24:0] : fa_r;
    vt       = {1'b0, ev_r} + {1'b0, pv_r};
    cur_rate = term_r ? rate_slow_r : rate_fast_r;
    cur_conv = term_r ? conv_slow_r : conv_fast_r;
    npr      = {1'b0, n_r} + {1'b0, r_r};
    twoav    = {avt_r, 1'b0};
    ne       = (npr >= {3'd0, twoav}) ? npr - {3'd0, twoav} : 61'd0;
    m_full   = {p[125:0], 2'b00};
    rate_num = {44'd0, af_r, 25'd0};
    out_load = (state_r == S_OUT) && (!out_valid_r || out_chan.ready);

    sc24a = scale(p, 24, tce_pkg::BIG_LIM, ca_r[31]);
    sc24v = scale(p, 24, tce_pkg::BIG_LIM, cv_r[31]);
    sc30s = scale(p, 30, tce_pkg::BIG_LIM, prev_cp_r[31]);
    sc13  = scale(p, 13, tce_pkg::CONV_LIM, s_r[33]);
    sc30d = scale(p, 30, tce_pkg::CONV_LIM, cur_conv[47]);
    sc28f = scale(p, 28, tce_pkg::BIG_LIM, conv_fast_r[47]);
    sc28s = scale(p, 28, tce_pkg::BIG_LIM, conv_slow_r[47]);
    cp_sum  = {{31{pa_r[32]}}, pa_r} + sc24v;
    dec_sum = sc30d + {{16{add_r[47]}}, add_r};
    out_sum = {{13{o1_r[50]}}, o1_r} + sc28s;

    // operand selection for the shared units
    mul_go    = 1'b0;
    ds_go     = 1'b0;
    mul_req.a = 64'd0;
    mul_req.b = 64'd0;
    ds_req.op  = tce_pkg::DS_DIV;
    ds_req.num = rate_num;
    ds_req.den = 64'd0;
    ds_req.cap = tce_pkg::RATE_MAX;
    case (state_r)
      S_TAB: begin
        mul_go    = (tidx_r != '0);
        mul_req.a = tab_r[tidx_r - 5'd1];
        mul_req.b = tab_r[tidx_r - 5'd1];
      end
      S_CPA: begin
        mul_go    = 1'b1;
        mul_req.a = mag64({{32{ca_r[31]}}, ca_r});
        mul_req.b = {39'd0, fa_c};
      end
      S_CPV: begin
        mul_go    = 1'b1;
        mul_req.a = mag64({{32{cv_r[31]}}, cv_r});
        mul_req.b = tce_pkg::ONE_Q24 - {39'd0, fa_c};
      end
      S_X: begin
        mul_go    = 1'b1;
        mul_req.a = {32'd0, dt};
        mul_req.b = {24'd0, cur_rate};
      end
      S_EXP: begin
        mul_go    = xb_r[0];
        mul_req.a = eacc_r;
        mul_req.b = tab_r[bidx_r];
      end
      S_S: begin
        mul_go    = 1'b1;
        mul_req.a = mag64({{32{prev_cp_r[31]}}, prev_cp_r});
        mul_req.b = {33'd0, e_r};
      end
      S_ADD: begin
        mul_go    = 1'b1;
        mul_req.a = mag64({{30{s_r[33]}}, s_r});
        mul_req.b = {32'd0, dt};
      end
      S_DEC: begin
        mul_go    = 1'b1;
        mul_req.a = mag64({{16{cur_conv[47]}}, cur_conv});
        mul_req.b = {33'd0, e_r};
      end
      S_OF: begin
        mul_go    = 1'b1;
        mul_req.a = mag64({{16{conv_fast_r[47]}}, conv_fast_r});
        mul_req.b = {33'd0, flow_fast_r};
      end
      S_OS: begin
        mul_go    = 1'b1;
        mul_req.a = mag64({{16{conv_slow_r[47]}}, conv_slow_r});
        mul_req.b = {33'd0, flow_slow_r};
      end
      S_AVT: begin
        mul_go    = 1'b1;
        mul_req.a = {36'd0, ps_r};
        mul_req.b = {35'd0, vt};
      end
      S_FEV: begin
        mul_go    = 1'b1;
        mul_req.a = {33'd0, pf_r};
        mul_req.b = {36'd0, ev_r};
      end
      S_N2: begin
        mul_go    = 1'b1;
        mul_req.a = {4'd0, n_r};
        mul_req.b = {4'd0, n_r};
      end
      S_AF: begin
        mul_go    = 1'b1;
        mul_req.a = {36'd0, ps_r};
        mul_req.b = {33'd0, pf_r};
      end
      S_EP: begin
        mul_go    = 1'b1;
        mul_req.a = {36'd0, ev_r};
        mul_req.b = {36'd0, pv_r};
      end
      S_M: begin
        mul_go    = 1'b1;
        mul_req.a = {5'd0, af_r};
        mul_req.b = {8'd0, ep_r};
      end
      S_NE: begin
        mul_go    = 1'b1;
        mul_req.a = {33'd0, pf_r};
        mul_req.b = {3'd0, ne};
      end
      S_SQ: begin
        ds_go      = 1'b1;
        ds_req.op  = tce_pkg::DS_SQRT;
        ds_req.num = {8'd0, n2_r};
      end
      S_RF: begin
        ds_go      = (n_r > r_r);
        ds_req.den = {4'd0, n_r - r_r};
      end
      S_RS: begin
        ds_go      = 1'b1;
        ds_req.den = {3'd0, npr};
      end
      S_FF: begin
        ds_go      = 1'b1;
        ds_req.num = {8'd0, n2_r};
        ds_req.den = {3'd0, r_r, 1'b0};
        ds_req.cap = {33'd0, pf_r};
      end
      S_K: begin
        ds_go      = 1'b1;
        ds_req.num = {73'd0, pf_r, 24'd0};
        ds_req.den = {36'd0, pv_r};
      end
      default: begin
        mul_go = 1'b0;
      end
    endcase
    mul_req.start = mul_go && !issued_r;
    ds_req.start  = ds_go && !issued_r;
    fire = issued_r && (mul_rsp.done || ds_rsp.done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_TAB;
      issued_r    <= 1'b0;
      tidx_r      <= '0;
      term_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pf_r        <= 31'd10066330;
      ps_r        <= 28'd3355443;
      ev_r        <= 28'd3355443;
      pv_r        <= 28'd3355443;
      fa_r        <= 25'd8388608;
      prev_time_r <= 32'd0;
      prev_cp_r   <= 32'sd0;
      conv_fast_r <= 48'sd0;
      conv_slow_r <= 48'sd0;
      rate_fast_r <= 40'd0;
      rate_slow_r <= 40'd0;
      flow_fast_r <= 31'd0;
      flow_slow_r <= 31'd0;
      invalid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tce_pkg::CFG_PLASMA_FLOW:   pf_r <= cfg_wdata;
          tce_pkg::CFG_PERM_SURFACE:  ps_r <= cfg_wdata[27:0];
          tce_pkg::CFG_EXTRA_VOLUME:  ev_r <= cfg_wdata[27:0];
          tce_pkg::CFG_PLASMA_VOLUME: pv_r <= cfg_wdata[27:0];
          tce_pkg::CFG_ART_FRACTION:  fa_r <= cfg_wdata[24:0];
          default: ;
        endcase
      end

      // hold the issue flag until the shared unit answers
      if ((mul_go || ds_go) && !issued_r) begin
        issued_r <= 1'b1;
      end
      if (fire) begin
        issued_r <= 1'b0;
      end

      // load a new result, or drop the old one once the receiver takes it
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_TAB: begin
          // build exp(-2^(i-24)) by repeated squaring
          if (tidx_r == '0) begin
            tab_r[0] <= tce_pkg::EXP_SEED;
            tidx_r   <= 5'd1;
          end else if (fire) begin
            tab_r[tidx_r] <= p[125:62];
            tidx_r        <= tidx_r + 5'd1;
            if (tidx_r == 5'(tce_pkg::EXP_BITS - 1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (in_chan.valid) begin
            st_r    <= in_chan.series_start;
            t_r     <= in_chan.sample_time;
            ca_r    <= in_chan.arterial_conc;
            cv_r    <= in_chan.venous_conc;
            state_r <= S_CPA;
          end
        end
        S_CPA: begin
          if (fire) begin
            pa_r    <= sc24a[32:0];
            state_r <= S_CPV;
          end
        end
        S_CPV: begin
          if (fire) begin
            cp_r   <= clamp32(cp_sum);
            term_r <= 1'b0;
            c_r    <= 32'sd0;
            if (st_r) begin
              state_r <= S_D0;
            end else if (invalid_r) begin
              state_r <= S_OUT;
            end else begin
              state_r <= S_ADV;
            end
          end
        end
        S_ADV: begin
          // a saturated rate drops its term
          if (cur_rate == tce_pkg::RATE_MAX[39:0]) begin
            if (term_r) begin
              conv_slow_r <= 48'sd0;
              state_r     <= S_OF;
            end else begin
              conv_fast_r <= 48'sd0;
              term_r      <= 1'b1;
            end
          end else begin
            state_r <= S_X;
          end
        end
        S_X: begin
          if (fire) begin
            if (|p[127:45]) begin
              e_r     <= 31'd0;
              state_r <= S_S;
            end else begin
              xb_r    <= p[44:16];
              bidx_r  <= '0;
              eacc_r  <= tce_pkg::EXP_ONE;
              state_r <= S_EXP;
            end
          end
        end
        S_EXP: begin
          // one table factor per set bit of the exponent argument
          if (xb_r == 29'd0) begin
            e_r     <= eacc_r[62:32];
            state_r <= S_S;
          end else if (!xb_r[0]) begin
            xb_r   <= xb_r >> 1;
            bidx_r <= bidx_r + 5'd1;
          end else if (fire) begin
            eacc_r <= p[125:62];
            xb_r   <= xb_r >> 1;
            bidx_r <= bidx_r + 5'd1;
          end
        end
        S_S: begin
          if (fire) begin
            s_r     <= {{2{cp_r[31]}}, cp_r} + sc30s[33:0];
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          if (fire) begin
            add_r   <= sc13[47:0];
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          if (fire) begin
            if (term_r) begin
              conv_slow_r <= clamp_conv(dec_sum);
              state_r     <= S_OF;
            end else begin
              conv_fast_r <= clamp_conv(dec_sum);
              term_r      <= 1'b1;
              state_r     <= S_ADV;
            end
          end
        end
        S_OF: begin
          if (fire) begin
            o1_r    <= sc28f[50:0];
            state_r <= S_OS;
          end
        end
        S_OS: begin
          if (fire) begin
            c_r     <= clamp32(out_sum);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_conc_r  <= c_r;
            out_err_r   <= invalid_r;
            prev_time_r <= t_r;
            prev_cp_r   <= cp_r;
            state_r     <= S_IDLE;
          end
        end
        S_D0: begin
          rate_fast_r <= 40'd0;
          rate_slow_r <= 40'd0;
          flow_fast_r <= 31'd0;
          flow_slow_r <= 31'd0;
          conv_fast_r <= 48'sd0;
          conv_slow_r <= 48'sd0;
          if (pf_r != '0 && ps_r != '0) begin
            if (vt == '0) begin
              invalid_r <= 1'b1;
              state_r   <= S_OUT;
            end else begin
              invalid_r <= 1'b0;
              state_r   <= S_AVT;
            end
          end else if (pf_r != '0) begin
            if (pv_r == '0 || ev_r == '0) begin
              invalid_r <= 1'b1;
              state_r   <= S_OUT;
            end else begin
              invalid_r <= 1'b0;
              state_r   <= S_K;
            end
          end else if (ps_r != '0) begin
            invalid_r <= (pv_r == '0 || ev_r == '0);
            state_r   <= S_OUT;
          end else begin
            invalid_r <= 1'b1;
            state_r   <= S_OUT;
          end
        end
        S_AVT: begin
          if (fire) begin
            avt_r   <= p[56:0];
            state_r <= S_FEV;
          end
        end
        S_FEV: begin
          if (fire) begin
            n_r     <= {3'd0, avt_r} + p[59:0];
            state_r <= S_N2;
          end
        end
        S_N2: begin
          if (fire) begin
            n2_r    <= p[119:0];
            state_r <= S_AF;
          end
        end
        S_AF: begin
          if (fire) begin
            af_r    <= p[58:0];
            state_r <= S_EP;
          end
        end
        S_EP: begin
          if (fire) begin
            ep_r    <= p[55:0];
            state_r <= S_M;
          end
        end
        S_M: begin
          // negative radicand leaves the series undefined
          if (fire) begin
            if (m_full > {8'd0, n2_r}) begin
              invalid_r <= 1'b1;
              state_r   <= S_OUT;
            end else begin
              n2_r    <= n2_r - m_full[119:0];
              state_r <= S_SQ;
            end
          end
        end
        S_SQ: begin
          if (fire) begin
            if (ds_rsp.res == 64'd0) begin
              invalid_r <= 1'b1;
              state_r   <= S_OUT;
            end else begin
              r_r     <= ds_rsp.res[59:0];
              state_r <= S_RF;
            end
          end
        end
        S_RF: begin
          if (n_r <= r_r) begin
            rate_fast_r <= tce_pkg::RATE_MAX[39:0];
            state_r     <= S_RS;
          end else if (fire) begin
            rate_fast_r <= ds_rsp.res[39:0];
            state_r     <= S_RS;
          end
        end
        S_RS: begin
          if (fire) begin
            rate_slow_r <= ds_rsp.res[39:0];
            state_r     <= S_NE;
          end
        end
        S_NE: begin
          if (fire) begin
            n2_r    <= p[119:0];
            state_r <= S_FF;
          end
        end
        S_FF: begin
          if (fire) begin
            flow_fast_r <= ds_rsp.res[30:0];
            flow_slow_r <= pf_r - ds_rsp.res[30:0];
            state_r     <= S_OUT;
          end
        end
        S_K: begin
          if (fire) begin
            rate_fast_r <= ds_rsp.res[39:0];
            flow_fast_r <= pf_r;
            state_r     <= S_OUT;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.tissue_conc = out_conc_r;
  assign out_chan.model_error = out_err_r;

endmodule

/* dv/two_compartment_exchange_conc_test.sv */
module two_compartment_exchange_conc_test;
  import tce_pkg::*;

  localparam int    STALL_LIMIT = 6000;   // cycles with no transaction before giving up
  localparam int    HOLD_CYCLES = 400;    // long receiver hold-off
  localparam int    MIX_SHIFT   = 24;
  localparam int    EXP_SHIFT   = 30;
  localparam int    AREA_SHIFT  = 13;     // 16 + 20 + 1 - 24
  localparam int    TISSUE_SHIFT = 28;    // 24 + 24 - 20
  localparam longint I32_MIN = -64'sd2147483648;
  localparam longint I32_MAX = 64'sd2147483647;

  typedef struct {
    logic [31:0] tissue;
    logic        err;
  } tissue_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  tce_in_if  in_if ();
  tce_out_if out_if ();

  two_compartment_exchange_conc uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Clock: period 10.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Tissue model predictor: own copy of registers and per-voxel state.
  // ---------------------------------------------------------------------------
  logic [63:0] reg_flow, reg_ps, reg_ve, reg_vp, reg_fa;
  logic [31:0] last_time;
  longint      last_plasma, conv_fast_acc, conv_slow_acc;
  logic [63:0] k_fast, k_slow, w_fast, w_slow;
  logic        constants_undefined;
  logic [63:0] decay_tab [EXP_BITS];

  tissue_result_t expected_tissue[$];
  int mismatches;

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> 62;
    return p[63:0];
  endfunction

  // exp(-x) for x in Q.24 below 2^29, result Q2.30
  function automatic logic [63:0] decay_factor(logic [63:0] x);
    logic [63:0] e;
    e = EXP_ONE;
    for (int i = 0; i < EXP_BITS; i++)
      if (x[i]) e = mul_q62(e, decay_tab[i]);
    return e >> 32;
  endfunction

  // Magnitude product, shifted and capped, sign restored (truncates to zero).
  function automatic longint scaled_mul(longint a, logic [63:0] b, int sh, logic [63:0] lim);
    logic [63:0]  mag;
    logic [127:0] p;
    logic [63:0]  m;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    p   = ({64'b0, mag} * {64'b0, b}) >> sh;
    m   = (p > {64'b0, lim}) ? lim : p[63:0];
    return (a < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [63:0] capped_div(logic [127:0] n, logic [63:0] d, logic [63:0] cap);
    logic [127:0] q;
    if (d == 0) return cap;
    q = n / {64'b0, d};
    return (q > {64'b0, cap}) ? cap : q[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [127:0] n);
    logic [63:0] r, c;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'b0, c} * {64'b0, c} <= n) r = c;
    end
    return r;
  endfunction

  // Rates and flow weights for a new series.
  task automatic derive_constants();
    logic [63:0]  vt, n, r, af, twoav, ne, k;
    logic [127:0] n2, m, num;
    k_fast = 0; k_slow = 0; w_fast = 0; w_slow = 0;
    constants_undefined = 1'b0;
    if (reg_flow > 0 && reg_ps > 0) begin
      vt = reg_ve + reg_vp;
      if (vt == 0) begin
        constants_undefined = 1'b1;
        return;
      end
      n  = reg_ps * vt + reg_flow * reg_ve;
      n2 = {64'b0, n} * {64'b0, n};
      af = reg_ps * reg_flow;
      m  = ({64'b0, af} * {64'b0, reg_ve * reg_vp}) << 2;
      if (m > n2) begin
        constants_undefined = 1'b1;
        return;
      end
      r = int_sqrt(n2 - m);
      if (r == 0) begin
        constants_undefined = 1'b1;
        return;
      end
      num    = {64'b0, af} << 25;
      k_fast = (n > r) ? capped_div(num, n - r, RATE_MAX) : RATE_MAX;
      k_slow = capped_div(num, n + r, RATE_MAX);
      twoav  = 2 * reg_ps * vt;
      ne     = (n + r >= twoav) ? n + r - twoav : 64'd0;
      w_fast = capped_div({64'b0, reg_flow} * {64'b0, ne}, 2 * r, reg_flow);
      w_slow = reg_flow - w_fast;
    end else if (reg_flow > 0) begin
      if (reg_vp == 0 || reg_ve == 0) begin
        constants_undefined = 1'b1;
        return;
      end
      k      = (reg_flow << 24) / reg_vp;
      k_fast = (k > RATE_MAX) ? RATE_MAX : k;
      w_fast = reg_flow;
    end else if (reg_ps > 0) begin
      if (reg_vp == 0 || reg_ve == 0) constants_undefined = 1'b1;
    end else begin
      constants_undefined = 1'b1;
    end
  endtask

  // One recursive trapezoid step of a convolution with exp(-k t).
  function automatic longint advance_conv(longint acc, logic [63:0] k, logic [31:0] dt,
                                          longint cp0, longint cp1);
    logic [127:0] x;
    logic [63:0]  e;
    longint       s, area;
    if (k >= RATE_MAX) return 0;
    x    = ({96'b0, dt} * {64'b0, k}) >> 16;
    e    = (x >= (128'd1 << EXP_BITS)) ? 64'd0 : decay_factor(x[63:0]);
    s    = cp1 + scaled_mul(cp0, e, EXP_SHIFT, BIG_LIM);
    area = scaled_mul(s, {32'b0, dt}, AREA_SHIFT, CONV_LIM);
    return clip(scaled_mul(acc, e, EXP_SHIFT, CONV_LIM) + area,
                -longint'(CONV_LIM), longint'(CONV_LIM));
  endfunction

  task automatic predict_tissue(logic start, logic [31:0] t, logic [31:0] ca, logic [31:0] cv);
    logic [63:0]    fa;
    longint         cp, c;
    logic [31:0]    dt;
    tissue_result_t res;
    fa = (reg_fa > ONE_Q24) ? ONE_Q24 : reg_fa;
    cp = clip(scaled_mul(longint'($signed(ca)), fa, MIX_SHIFT, BIG_LIM)
              + scaled_mul(longint'($signed(cv)), ONE_Q24 - fa, MIX_SHIFT, BIG_LIM),
              I32_MIN, I32_MAX);
    c = 0;
    if (start) begin
      derive_constants();
      conv_fast_acc = 0;
      conv_slow_acc = 0;
    end else if (!constants_undefined) begin
      dt = (t >= last_time) ? t - last_time : 32'd0;
      conv_fast_acc = advance_conv(conv_fast_acc, k_fast, dt, last_plasma, cp);
      conv_slow_acc = advance_conv(conv_slow_acc, k_slow, dt, last_plasma, cp);
      c = clip(scaled_mul(conv_fast_acc, w_fast, TISSUE_SHIFT, BIG_LIM)
               + scaled_mul(conv_slow_acc, w_slow, TISSUE_SHIFT, BIG_LIM),
               I32_MIN, I32_MAX);
    end
    last_time   = t;
    last_plasma = cp;
    res.tissue  = c[31:0];
    res.err     = constants_undefined;
    expected_tissue.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Handshake processes
  // ---------------------------------------------------------------------------
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_request;
  int stall_cycles;

  // Sender: draw a gap, offer the sample, hold it until the transaction goes through.
  task automatic send_sample(logic start, logic [31:0] t, logic [31:0] ca, logic [31:0] cv);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.series_start  <= start;
    in_if.sample_time   <= t;
    in_if.arterial_conc <= ca;
    in_if.venous_conc   <= cv;
    do @(posedge clk); while (!in_if.ready);
    predict_tissue(start, t, ca, cv);
  endtask

  // Drop valid, then wait until every expected result has drained.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_tissue.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all five registers back to back; only call while idle.
  task automatic write_model_regs(logic [63:0] f, logic [63:0] ps, logic [63:0] ve,
                                  logic [63:0] vp, logic [63:0] fa);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [63:0]          val [5];
    idx = '{CFG_PLASMA_FLOW, CFG_PERM_SURFACE, CFG_EXTRA_VOLUME, CFG_PLASMA_VOLUME,
            CFG_ART_FRACTION};
    val = '{f, ps, ve, vp, fa};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i][CFG_W-1:0];
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    reg_flow = f & 64'h7FFF_FFFF;
    reg_ps   = ps & 64'h0FFF_FFFF;
    reg_ve   = ve & 64'h0FFF_FFFF;
    reg_vp   = vp & 64'h0FFF_FFFF;
    reg_fa   = fa & 64'h01FF_FFFF;
  endtask

  // Receiver: random stall per result, plus one long hold-off on request.
  initial begin
    int n;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = rx_idle_on ? $urandom_range(0, 4) : 0;
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    tissue_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_tissue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: tissue_conc=%h model_error=%b",
                   out_if.tissue_conc, out_if.model_error);
      end else begin
        want = expected_tissue.pop_front();
        if (out_if.tissue_conc !== want.tissue || out_if.model_error !== want.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: tissue_conc exp %h got %h, model_error exp %b got %b",
                     want.tissue, out_if.tissue_conc, want.err, out_if.model_error);
        end
      end
    end
  end

  // Watchdog: count cycles in which no transaction of any kind happens.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Samples before any series start run on the reset state: zero, no error.
  task automatic test_before_series();
    send_sample(1'b0, 32'h0001_0000, 32'h0010_0000, 32'h0020_0000);
    send_sample(1'b0, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(1'b0, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001);
  endtask

  // Field extremes under the reset registers, then the fraction above one and at zero.
  task automatic test_field_extremes();
    send_sample(1'b1, 32'h0000_0000, 32'h0010_0000, 32'h0008_0000);
    send_sample(1'b0, 32'h0000_8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(1'b0, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000);
    send_sample(1'b0, 32'h0000_4000, 32'h0040_0000, 32'hFFC0_0000); // time runs backwards
    send_sample(1'b0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0002_0000); // huge step: full decay
    send_sample(1'b0, 32'hFFFF_FFFF, 32'h0030_0000, 32'h0000_0000); // zero step
    drain();
    // arterial fraction above one clamps to one; fully venous with zero
    write_model_regs(64'd10066330, 64'd3355443, 64'd3355443, 64'd3355443, 64'h01FF_FFFF);
    send_sample(1'b1, 32'h0000_0000, 32'h0010_0000, 32'h7FFF_FFFF);
    send_sample(1'b0, 32'h0000_8000, 32'h0020_0000, 32'h7FFF_FFFF);
    drain();
    write_model_regs(64'd10066330, 64'd3355443, 64'd3355443, 64'd3355443, 64'd0);
    send_sample(1'b1, 32'h0000_0000, 32'h0010_0000, 32'h0010_0000);
    send_sample(1'b0, 32'h0000_8000, 32'h8000_0000, 32'h0040_0000);
    drain();
  endtask

  // One start plus one sample under a given register set.
  task automatic try_constants(logic [63:0] f, logic [63:0] ps, logic [63:0] ve,
                               logic [63:0] vp);
    write_model_regs(f, ps, ve, vp, 64'd8388608);
    send_sample(1'b1, 32'h0000_0000, 32'h0010_0000, 32'h0010_0000);
    send_sample(1'b0, 32'h0000_4000, 32'h0020_0000, 32'h0010_0000);
    drain();
  endtask

  // Undefined constants, degenerate forms and a saturated rate.
  task automatic test_special_constants();
    try_constants(64'd10066330, 64'd3355443, 64'd0, 64'd0);        // no volume at all
    try_constants(64'd0, 64'd0, 64'd3355443, 64'd3355443);          // no flow and no PS
    try_constants(64'd10066330, 64'd0, 64'd0, 64'd3355443);         // PS zero, ve zero
    try_constants(64'd10066330, 64'd0, 64'd3355443, 64'd3355443);   // single compartment
    try_constants(64'd0, 64'd3355443, 64'd3355443, 64'd3355443);    // no flow: zero output
    try_constants(64'h7FFF_FFFF, 64'd0, 64'd3355443, 64'd1);        // rate saturates, term dropped
    try_constants(64'd1677721600, 64'd167772160, 64'd167772160, 64'd167772160);
  endtask

  function automatic logic [63:0] pick_reg(logic [63:0] typ_lo, logic [63:0] typ_hi,
                                           logic [63:0] range_hi, logic [63:0] full);
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return range_hi;
      2:       return full;
      3:       return {$urandom, $urandom} & full;
      4:       return 64'($urandom_range(0, 64)) & full;
      default: return 64'($urandom_range(int'(typ_lo), int'(typ_hi)));
    endcase
  endfunction

  // A series: a start, then well-formed steps, with some noise mixed in.
  task automatic run_series(int count);
    logic [31:0] t;
    logic [31:0] ca, cv;
    int          span;
    t = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0010_0000);
    span = $urandom_range(0, 3) == 0 ? 32'h0004_0000 : 32'h0000_8000;
    send_sample(1'b1, t, $urandom, $urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any time, any concentration, maybe a stray start
        send_sample($urandom_range(0, 3) == 0, $urandom, $urandom, $urandom);
      end else begin
        t  = t + $urandom_range(0, span);
        ca = $urandom_range(0, 4) == 0 ? $urandom : 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
        cv = $urandom_range(0, 4) == 0 ? $urandom : 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
        send_sample(1'b0, t, ca, cv);
      end
    end
  endtask

  // Random register sets, each followed by a few random series.
  task automatic test_random_series(int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      write_model_regs(pick_reg(64'h0010_0000, 64'h0800_0000, 64'd1677721600, 64'h7FFF_FFFF),
                       pick_reg(64'h0004_0000, 64'h0400_0000, 64'd167772160, 64'h0FFF_FFFF),
                       pick_reg(64'h0010_0000, 64'h0100_0000, 64'd167772160, 64'h0FFF_FFFF),
                       pick_reg(64'h0010_0000, 64'h0100_0000, 64'd167772160, 64'h0FFF_FFFF),
                       pick_reg(64'h0, 64'h0100_0000, 64'd16777216, 64'h01FF_FFFF));
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      for (int s = 0; s < 3; s++) begin
        n = $urandom_range(4, 20);
        run_series(n);
        sent += n + 1;
      end
      drain();
    end
  endtask

  // Receiver holds off for a long stretch while samples keep coming.
  task automatic test_receiver_hold();
    write_model_regs(64'd10066330, 64'd3355443, 64'd3355443, 64'd3355443, 64'd8388608);
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    hold_request = 1'b1;
    run_series(12);
    drain();
    rx_idle_on = 1'b1;
    tx_idle_on = 1'b1;
  endtask

  initial begin
    logic [63:0] q;
    q = EXP_SEED;
    for (int i = 0; i < EXP_BITS; i++) begin
      decay_tab[i] = q;
      q = mul_q62(q, q);
    end
    reg_flow = 64'd10066330;
    reg_ps   = 64'd3355443;
    reg_ve   = 64'd3355443;
    reg_vp   = 64'd3355443;
    reg_fa   = 64'd8388608;
    last_time = 0; last_plasma = 0; conv_fast_acc = 0; conv_slow_acc = 0;
    k_fast = 0; k_slow = 0; w_fast = 0; w_slow = 0;
    constants_undefined = 1'b0;
    mismatches   = 0;
    stall_cycles = 0;
    hold_request = 1'b0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_PLASMA_FLOW;
    cfg_wdata           <= '0;
    in_if.valid         <= 1'b0;
    in_if.series_start  <= 1'b0;
    in_if.sample_time   <= '0;
    in_if.arterial_conc <= '0;
    in_if.venous_conc   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_series();
    drain();
    test_field_extremes();
    test_special_constants();
    test_receiver_hold();
    test_random_series(1400);
    drain();
    repeat (40) @(posedge clk);

    if (mismatches == 0 && expected_tissue.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
